FILE: hw/rtl/background_model_foreground_mask_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef BACKGROUND_MODEL_FOREGROUND_MASK_MACROS_SVH
`define BACKGROUND_MODEL_FOREGROUND_MASK_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define BMFM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmfm: same-cycle check failed");

// Next-cycle implication
`define BMFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmfm: next-cycle check failed");

`endif

FILE: hw/rtl/bmfm_pkg.sv
`default_nettype none

package bmfm_pkg;

    // Frame geometry and learning limits
    localparam int MAX_PIXELS       = 524288;
    localparam int MAX_LEARN_FRAMES = 64;
    localparam int POS_W            = $clog2(MAX_PIXELS);
    localparam int POS_CNT_W        = POS_W + 1;
    localparam int N_W              = $clog2(MAX_LEARN_FRAMES + 1);
    localparam int FC_W             = $clog2(MAX_LEARN_FRAMES + 2);

    // Field and register widths
    localparam int PIX_W    = 8;
    localparam int LF_W     = 7;
    localparam int WEIGHT_W = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    // Model store widths
    localparam int SUM_W = 14;
    localparam int SQ_W  = 22;
    localparam int ENTRY_W = SUM_W + SQ_W;

    // Datapath widths
    localparam int PSQ_W = 2 * PIX_W;
    localparam int DIV_CHUNK = SUM_W / 2;
    localparam int ND_W  = N_W + SUM_W;
    localparam int WD_W  = WEIGHT_W + SQ_W;
    localparam int MM_W  = 2 * SUM_W;
    localparam int NMM_W = N_W + MM_W;
    localparam int A_W   = NMM_W + 1;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT       = 1'd1;
    localparam logic [LF_W-1:0]      LEARN_FRAMES_RST = 7'd20;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_RST       = 8'd4;

    // Per-item phase
    localparam logic [1:0] PH_LEARN_FIRST = 2'd0;
    localparam logic [1:0] PH_LEARN_ADD   = 2'd1;
    localparam logic [1:0] PH_CONVERT     = 2'd2;
    localparam logic [1:0] PH_DETECT      = 2'd3;

    typedef struct packed {
        logic [1:0]       phase;
        logic             in_range;
        logic [POS_W-1:0] pos;
        logic [PIX_W-1:0] pix;
        logic             eof;
    } item_t;

    typedef struct packed {
        logic hazard;
        logic res_valid;
        logic foreground;
        logic last_of_frame;
    } status_t;

    typedef struct packed {
        logic [N_W-1:0]       rem;
        logic [DIV_CHUNK-1:0] quo;
    } div_part_t;

    // Restoring division over one chunk of dividend bits
    function automatic div_part_t div_chunk(
        input logic [N_W-1:0]       rem_in,
        input logic [DIV_CHUNK-1:0] bits,
        input logic [N_W-1:0]       divisor
    );
        logic [N_W:0] r;
        div_part_t    res;
        r = {1'b0, rem_in};
        res.quo = '0;
        for (int i = DIV_CHUNK - 1; i >= 0; i--) begin
            r = {r[N_W-1:0], bits[i]};
            if (r >= {1'b0, divisor}) begin
                r = r - {1'b0, divisor};
                res.quo[i] = 1'b1;
            end
        end
        res.rem = r[N_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bmfm_pixel_if.sv
`default_nettype none

interface bmfm_pixel_if;
    import bmfm_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             end_of_frame;

    modport source (output valid, output pixel, output end_of_frame, input ready);
    modport sink   (input valid, input pixel, input end_of_frame, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bmfm_mask_if.sv
`default_nettype none

interface bmfm_mask_if;
    logic valid;
    logic ready;
    logic foreground;
    logic last_of_frame;

    modport source (output valid, output foreground, output last_of_frame, input ready);
    modport sink   (input valid, input foreground, input last_of_frame, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bmfm_model.sv
`default_nettype none
`include "background_model_foreground_mask_macros.svh"

module bmfm_model (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          accept,
    input  bmfm_pkg::item_t               item,
    input  logic [bmfm_pkg::N_W-1:0]      n_eff,
    input  logic [bmfm_pkg::WEIGHT_W-1:0] weight,
    output bmfm_pkg::status_t             status
);
    import bmfm_pkg::*;

    // Per-pixel model store: {sum or mean, squares or deviation}
    logic [ENTRY_W-1:0] mem [MAX_PIXELS];
    logic [ENTRY_W-1:0] rdata_reg;
    logic               ram_re;
    logic               ram_we;
    logic [POS_W-1:0]   ram_raddr;
    logic [POS_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    // Stage control
    item_t      stg_reg [1:5];
    logic [5:1] vld_reg;

    // Stage 2 payload
    logic [SUM_W-1:0]     sum2_reg, sum2_next;
    logic [SQ_W-1:0]      sq2_reg, sq2_next;
    logic [N_W-1:0]       rem2_reg;
    logic [DIV_CHUNK-1:0] quo2_reg;
    logic [SUM_W-1:0]     d2_reg, d2_next;
    // Stage 3 payload
    logic [SUM_W-1:0] sum3_reg, m3_reg;
    logic [SQ_W-1:0]  sq3_reg;
    logic [ND_W-1:0]  nd3_reg;
    logic [WD_W-1:0]  wd3_reg;
    // Stage 4 payload
    logic [SUM_W-1:0] sum4_reg, m4_reg;
    logic [SQ_W-1:0]  sq4_reg;
    logic [MM_W-1:0]  mm4_reg, ms4_reg;
    logic             fg4_reg;
    // Stage 5 payload
    logic [SUM_W-1:0] sum5_reg, m5_reg;
    logic [SQ_W-1:0]  sq5_reg;
    logic [NMM_W-1:0] nmm5_reg;
    logic [MM_W-1:0]  ms5_reg;
    logic             fg5_reg;

    logic [SUM_W-1:0] rd_sum;
    logic [SQ_W-1:0]  rd_sq;
    logic [PSQ_W-1:0] pix_sq;
    div_part_t        div1, div2;
    logic [A_W-1:0]   dev_a, dev_b, dev_full;
    logic             hazard;

    function automatic logic writes_back(input item_t it);
        return it.in_range && (it.phase != PH_DETECT);
    endfunction

    // Memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            mem[ram_waddr] <= ram_wdata;
        end
        if (ram_re)
        begin
            rdata_reg <= mem[ram_raddr];
        end
    end

    assign ram_re    = accept && item.in_range;
    assign ram_raddr = item.pos;

    // Interlock: hold off an item whose entry is still on its way back
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 1; k <= 5; k++)
        begin
            if (item.in_range && vld_reg[k] && writes_back(stg_reg[k])
                && (stg_reg[k].pos == item.pos))
            begin
                hazard = 1'b1;
            end
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[4:1], accept};
        end
    end

    // Stage 1: accumulate, first half of the division, absolute difference
    assign rd_sum = rdata_reg[ENTRY_W-1:SQ_W];
    assign rd_sq  = rdata_reg[SQ_W-1:0];
    assign pix_sq = PSQ_W'(stg_reg[1].pix) * PSQ_W'(stg_reg[1].pix);
    assign div1   = div_chunk('0, rd_sum[SUM_W-1:DIV_CHUNK], n_eff);

    always_comb
    begin
        case (stg_reg[1].phase)
            PH_LEARN_FIRST:
            begin
                sum2_next = SUM_W'(stg_reg[1].pix);
                sq2_next  = SQ_W'(pix_sq);
            end
            PH_LEARN_ADD:
            begin
                sum2_next = rd_sum + SUM_W'(stg_reg[1].pix);
                sq2_next  = rd_sq + SQ_W'(pix_sq);
            end
            default:
            begin
                sum2_next = rd_sum;
                sq2_next  = rd_sq;
            end
        endcase
        if (SUM_W'(stg_reg[1].pix) > rd_sum)
        begin
            d2_next = SUM_W'(stg_reg[1].pix) - rd_sum;
        end
        else
        begin
            d2_next = rd_sum - SUM_W'(stg_reg[1].pix);
        end
    end

    // Stage 2: second half of the division
    assign div2 = div_chunk(rem2_reg, sum2_reg[DIV_CHUNK-1:0], n_eff);

    // Stage 5: deviation sum and write-back
    assign dev_a    = A_W'(sq5_reg) + A_W'(nmm5_reg);
    assign dev_b    = A_W'({ms5_reg, 1'b0});
    assign dev_full = (dev_a > dev_b) ? (dev_a - dev_b) : '0;

    assign ram_we    = adv && vld_reg[5] && writes_back(stg_reg[5]);
    assign ram_waddr = stg_reg[5].pos;
    assign ram_wdata = (stg_reg[5].phase == PH_CONVERT)
                     ? {m5_reg, dev_full[SQ_W-1:0]}
                     : {sum5_reg, sq5_reg};

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_reg[1] <= item;
            for (int k = 2; k <= 5; k++)
            begin
                stg_reg[k] <= stg_reg[k-1];
            end

            sum2_reg <= sum2_next;
            sq2_reg  <= sq2_next;
            rem2_reg <= div1.rem;
            quo2_reg <= div1.quo;
            d2_reg   <= d2_next;

            sum3_reg <= sum2_reg;
            sq3_reg  <= sq2_reg;
            m3_reg   <= {quo2_reg, div2.quo};
            nd3_reg  <= ND_W'(n_eff) * ND_W'(d2_reg);
            wd3_reg  <= WD_W'(weight) * WD_W'(sq2_reg);

            sum4_reg <= sum3_reg;
            sq4_reg  <= sq3_reg;
            m4_reg   <= m3_reg;
            mm4_reg  <= MM_W'(m3_reg) * MM_W'(m3_reg);
            ms4_reg  <= MM_W'(m3_reg) * MM_W'(sum3_reg);
            fg4_reg  <= stg_reg[3].in_range && (WD_W'({nd3_reg, 2'b00}) > wd3_reg);

            sum5_reg <= sum4_reg;
            sq5_reg  <= sq4_reg;
            m5_reg   <= m4_reg;
            nmm5_reg <= NMM_W'(n_eff) * NMM_W'(mm4_reg);
            ms5_reg  <= ms4_reg;
            fg5_reg  <= fg4_reg;
        end
    end

    assign status.hazard        = hazard;
    assign status.res_valid     = vld_reg[5] && (stg_reg[5].phase == PH_DETECT);
    assign status.foreground    = fg5_reg;
    assign status.last_of_frame = stg_reg[5].eof;

    `BMFM_ASSERT_IMPLIES(a_no_rw_clash, clk, rst_n, ram_re && ram_we, ram_raddr != ram_waddr)
    `BMFM_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, !adv && vld_reg[5], vld_reg[5] && $stable(stg_reg[5]))
    `BMFM_ASSERT_IMPLIES(a_mean_le_sum, clk, rst_n, ram_we && (stg_reg[5].phase == PH_CONVERT), m5_reg <= sum5_reg)

endmodule

`default_nettype wire

FILE: hw/rtl/background_model_foreground_mask.sv
// Background subtraction on a raster grayscale stream. For the first N frames
// (N = learn_frames, 0 taken as 1 and clipped at 64) each pixel position keeps a
// running sum and sum of squares; frame N turns them into mean and summed squared
// deviation; from frame N+1 on each pixel yields one mask item, foreground set when
// 4*N*|pixel-mean| > weight_q2*deviation. No mask items come out during frames 0..N.
// Throughput is one pixel per clock while the output buffer has room: a five-stage
// read-modify-write pipeline around a single-port-write, single-port-read model
// memory (524288 entries of 36 bits). A pixel waits while its own entry is still
// being written back, which only happens for frames shorter than six pixels.
// The model memory is not cleared after reset: the first learning frame writes
// every entry it touches, and later frames must not be longer. Pixels past the
// memory capacity are not stored and give background. Change the registers only
// while the block is idle.
`default_nettype none
`include "background_model_foreground_mask_macros.svh"

module background_model_foreground_mask (
    input  logic                            clk,
    input  logic                            rst_n,
    bmfm_pixel_if.sink                      pixels,
    bmfm_mask_if.source                     masks,
    input  logic                            cfg_we,
    input  logic [bmfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmfm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bmfm_pkg::*;

    localparam int OUT_DEPTH = 2;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    logic [LF_W-1:0]      learn_frames_reg;
    logic [WEIGHT_W-1:0]  weight_reg;
    logic [POS_CNT_W-1:0] pos_reg;
    logic [FC_W-1:0]      frame_count_reg;

    logic [N_W-1:0]  n_eff;
    logic [FC_W-1:0] n_fc;
    item_t           item;
    status_t         status;
    logic            adv;
    logic            accept;
    logic            push;
    logic            pop;

    logic                 out_fg_reg   [OUT_DEPTH];
    logic                 out_last_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] cnt_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_frames_reg <= LEARN_FRAMES_RST;
            weight_reg       <= WEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEARN_FRAMES: learn_frames_reg <= cfg_data[LF_W-1:0];
                REG_WEIGHT:       weight_reg       <= cfg_data[WEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective learn count
    always_comb
    begin
        if (learn_frames_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (LF_W'(learn_frames_reg) > LF_W'(MAX_LEARN_FRAMES))
        begin
            n_eff = N_W'(MAX_LEARN_FRAMES);
        end
        else
        begin
            n_eff = N_W'(learn_frames_reg);
        end
    end

    // Phase of the incoming item
    assign n_fc = FC_W'(n_eff);

    always_comb
    begin
        if (frame_count_reg < n_fc)
        begin
            item.phase = (frame_count_reg == '0) ? PH_LEARN_FIRST : PH_LEARN_ADD;
        end
        else if (frame_count_reg == n_fc)
        begin
            item.phase = PH_CONVERT;
        end
        else
        begin
            item.phase = PH_DETECT;
        end
        item.in_range = !pos_reg[POS_W];
        item.pos      = pos_reg[POS_W-1:0];
        item.pix      = pixels.pixel;
        item.eof      = pixels.end_of_frame;
    end

    // Handshake and pipeline advance
    assign adv          = !(status.res_valid && (cnt_reg == OUT_CNT_W'(OUT_DEPTH)));
    assign pixels.ready = adv && !status.hazard;
    assign accept       = pixels.valid && pixels.ready;
    assign push         = status.res_valid && adv;
    assign pop          = masks.valid && masks.ready;

    // Position and frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            frame_count_reg <= '0;
        end
        else if (accept)
        begin
            if (pixels.end_of_frame)
            begin
                pos_reg <= '0;
                if (frame_count_reg < FC_W'(MAX_LEARN_FRAMES + 1))
                begin
                    frame_count_reg <= frame_count_reg + 1'b1;
                end
            end
            else if (item.in_range)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    bmfm_model u_model (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .accept (accept),
        .item   (item),
        .n_eff  (n_eff),
        .weight (weight_reg),
        .status (status)
    );

    // Output buffer: lets the pipeline run while a mask item waits
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_fg_reg[wr_ptr_reg]   <= status.foreground;
            out_last_reg[wr_ptr_reg] <= status.last_of_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= OUT_PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= OUT_PTR_W'(rd_ptr_reg + 1'b1);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: ;
            endcase
        end
    end

    assign masks.valid         = (cnt_reg != '0);
    assign masks.foreground    = out_fg_reg[rd_ptr_reg];
    assign masks.last_of_frame = out_last_reg[rd_ptr_reg];

    `BMFM_ASSERT_IMPLIES(a_result_only_detect, clk, rst_n, push, frame_count_reg > n_fc)
    `BMFM_ASSERT_IMPLIES(a_buffer_bound, clk, rst_n, 1'b1, cnt_reg <= OUT_CNT_W'(OUT_DEPTH))
    `BMFM_ASSERT_NEXT(a_eof_rewinds, clk, rst_n, accept && pixels.end_of_frame, pos_reg == '0)

endmodule

`default_nettype wire
